>>> rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared constants of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    // default ring size in slots (a power of two)
    localparam int DEF_WINDOW_DEPTH = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RETX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US    = 2'd2;

    // commands
    localparam logic [1:0] CMD_ACK  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_SEND = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_PACKET  = 2'd1;
    localparam logic [1:0] KIND_NOTHING = 2'd2;

    // slot status codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_NOT_SENT = 3'd0;
    localparam logic [ST_W-1:0] ST_SENT     = 3'd1;
    localparam logic [ST_W-1:0] ST_TIMEOUT  = 3'd2;
    localparam logic [ST_W-1:0] ST_RESENT   = 3'd3;
    localparam logic [ST_W-1:0] ST_ACKED    = 3'd4;

    // window arithmetic
    localparam int WIN_MIN    = 10;
    localparam int THRESH_MIN = 20;
    localparam int GROW_STEP  = 20;
    localparam logic [15:0] SSTHRESH_INIT = 16'hFFFF;
    localparam logic [31:0] TIMEOUT_INIT  = 32'd100000;

    // floor(x*62/100) as x*62*ceil(2^24/100) >> 24
    localparam int SHRINK_MUL   = 62 * 167773;
    localparam int SHRINK_SHIFT = 24;

endpackage

>>> rtl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of a selective-repeat window with congestion control.
// ----------------------------------------------------------------------------
// Usage: one input item carries a command (ack, timeout tick, send request)
// on a valid/ready channel; results leave on a valid/ready channel, the last
// result of an item flagged by o_last. Configuration is a plain write port
// (i_cfg_we, i_cfg_idx, i_cfg_data) used while the block is idle; writing
// total_packets restarts the transfer.
// The slot ring sits in a RAM with one registered read port, so each visited
// slot is first presented to the read port (S_SCAN_RD) and then acted on
// (S_SCAN_EX). An ack scans at most min(cwnd, filled) slots when the ready
// rescan runs; a tick scans every filled slot; a send scans min(cwnd, filled).
// The block takes one item at a time; o_in_ready is high only while idle.
// Reset: synchronous, active low; restores the state of a fresh transfer of
// one packet (window 10, threshold unlimited, all slots not sent).
// Stall: results sit in an output register; when the receiver holds off, the
// sequencer waits on the next result and resumes without loss.
// WINDOW_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
    parameter int WINDOW_DEPTH = srsw_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [31:0]                    i_cum_seq,
    input  logic [31:0]                    i_sel_seq,
    input  logic [31:0]                    i_now_us,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_kind,
    output logic [31:0]                    o_seq_num,
    output logic                           o_is_final_packet,
    output logic                           o_last,
    output logic [6:0]                     o_cwnd_out,
    output logic [15:0]                    o_ssthresh_out,
    output logic                           o_done_res,
    output logic                           o_data_ready,
    output logic                           o_ack_error
);

    import srsw_pkg::*;

    localparam int SW = $clog2(WINDOW_DEPTH);
    localparam int CW = SW + 1;
    localparam logic [CW-1:0] DEPTH_C  = CW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] WIN_INIT =
        CW'((WIN_MIN > WINDOW_DEPTH) ? WINDOW_DEPTH : WIN_MIN);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ACK_MARK = 4'd1;
    localparam logic [3:0] S_ACK_RD   = 4'd2;
    localparam logic [3:0] S_ACK_DUP  = 4'd3;
    localparam logic [3:0] S_ACK_SLID = 4'd4;
    localparam logic [3:0] S_ACK_GROW = 4'd5;
    localparam logic [3:0] S_ACK_FILL = 4'd6;
    localparam logic [3:0] S_SCAN_RD  = 4'd7;
    localparam logic [3:0] S_SCAN_EX  = 4'd8;
    localparam logic [3:0] S_TICK_END = 4'd9;
    localparam logic [3:0] S_SEND_END = 4'd10;
    localparam logic [3:0] S_STAT     = 4'd11;

    // saturating mark base + w
    function automatic logic [31:0] f_mark(input logic [31:0] base, input logic [CW-1:0] w);
        logic [32:0] sum;
        sum = {1'b0, base} + 33'(w);
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // max(20, floor(cwnd*62/100))
    function automatic logic [15:0] f_shrink(input logic [CW-1:0] c);
        logic [CW+24-1:0] prod;
        logic [15:0]      t;
        prod = (CW+24)'(c) * (CW+24)'(SHRINK_MUL);
        t    = 16'(prod >> SHRINK_SHIFT);
        return (t < 16'(THRESH_MIN)) ? 16'(THRESH_MIN) : t;
    endfunction

    // ring offset of a slot from the base slot
    function automatic logic [SW-1:0] f_off(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return a - b;
    endfunction

    // configuration and window state
    logic [31:0]             r_total, n_total;
    logic                    r_fast, n_fast;
    logic [31:0]             r_timeout, n_timeout;
    logic [31:0]             r_base, n_base;
    logic [CW-1:0]           r_filled, n_filled;
    logic [CW-1:0]           r_cwnd, n_cwnd;
    logic [15:0]             r_ss, n_ss;
    logic [31:0]             r_mark, n_mark;
    logic [31:0]             r_high, n_high;
    logic [1:0]              r_dup, n_dup;
    logic                    r_pun, n_pun;
    logic                    r_rdy, n_rdy;
    logic [WINDOW_DEPTH-1:0] r_vld, n_vld;

    // sequencer
    logic [3:0]              r_state, n_state;
    logic [1:0]              r_cmd, n_cmd;
    logic [31:0]             r_cum, n_cum;
    logic [31:0]             r_sel, n_sel;
    logic [31:0]             r_now, n_now;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_err, n_err;
    logic                    r_some, n_some;
    logic                    r_flo, n_flo;
    logic                    r_fall, n_fall;
    logic                    r_pend_v, n_pend_v;
    logic [31:0]             r_pend_seq, n_pend_seq;

    // output register
    logic                    r_out_valid;
    logic [1:0]              r_kind;
    logic [31:0]             r_seq;
    logic                    r_fin, r_last, r_done, r_dready, r_aerr;
    logic [6:0]              r_cwnd_o;
    logic [15:0]             r_ss_o;

    // emission request
    logic                    emit;
    logic [1:0]              e_kind;
    logic [31:0]             e_seq;
    logic                    e_last, e_err;

    // ram ports
    logic                    st_we, tm_we;
    logic [SW-1:0]           st_waddr, raddr;
    logic [ST_W-1:0]         st_wdata, st_rd, st_eff;
    logic [31:0]             tm_rd;

    // scratch
    logic [31:0]             scan_seq, d, avail, elapsed;
    logic [SW-1:0]           base_slot;
    logic [CW-1:0]           lim, win_lim, target, c_new;
    logic [1:0]              dup_n;
    logic [15:0]             ss_new;
    logic [16:0]             g;
    logic                    out_free, timed;
    logic [ST_W-1:0]         st_post;

    srsw_ram #(.WIDTH(ST_W), .DEPTH(WINDOW_DEPTH)) u_status (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (raddr),
        .o_rdata (st_rd)
    );

    srsw_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_sent_time (
        .i_clk   (i_clk),
        .i_we    (tm_we),
        .i_waddr (st_waddr),
        .i_wdata (r_now),
        .i_raddr (raddr),
        .o_rdata (tm_rd)
    );

    // address and limit helpers
    assign scan_seq  = r_base + 32'(r_idx);
    assign base_slot = r_base[SW-1:0];
    assign raddr     = (r_state == S_ACK_RD || r_state == S_ACK_DUP) ? base_slot
                                                                    : scan_seq[SW-1:0];
    assign st_eff    = r_vld[raddr] ? st_rd : ST_NOT_SENT;
    assign win_lim   = (r_cwnd < r_filled) ? r_cwnd : r_filled;
    assign lim       = (r_cmd == CMD_TICK) ? r_filled : win_lim;
    assign out_free  = !r_out_valid || i_out_ready;
    assign elapsed   = r_now - tm_rd;
    assign o_in_ready = (r_state == S_IDLE);

    // sequencer and window update
    always_comb begin
        n_total = r_total;   n_fast = r_fast;     n_timeout = r_timeout;
        n_base = r_base;     n_filled = r_filled; n_cwnd = r_cwnd;
        n_ss = r_ss;         n_mark = r_mark;     n_high = r_high;
        n_dup = r_dup;       n_pun = r_pun;       n_rdy = r_rdy;
        n_vld = r_vld;       n_state = r_state;   n_cmd = r_cmd;
        n_cum = r_cum;       n_sel = r_sel;       n_now = r_now;
        n_idx = r_idx;       n_err = r_err;       n_some = r_some;
        n_flo = r_flo;       n_fall = r_fall;     n_pend_v = r_pend_v;
        n_pend_seq = r_pend_seq;
        emit = 1'b0;  e_kind = KIND_STATUS;  e_seq = '0;  e_last = 1'b0;  e_err = 1'b0;
        st_we = 1'b0; tm_we = 1'b0; st_waddr = scan_seq[SW-1:0]; st_wdata = ST_NOT_SENT;
        d = '0; avail = '0; target = '0; c_new = '0; dup_n = '0; ss_new = '0; g = '0;
        timed = 1'b0; st_post = st_eff;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_cmd; n_cum = i_cum_seq; n_sel = i_sel_seq; n_now = i_now_us;
                    n_err = 1'b0; n_idx = '0; n_some = 1'b0; n_flo = 1'b0; n_fall = 1'b0;
                    n_pend_v = 1'b0;
                    case (i_cmd)
                        CMD_ACK:  n_state = S_ACK_MARK;
                        CMD_TICK: n_state = S_SCAN_RD;
                        CMD_SEND: n_state = S_SCAN_RD;
                        default:  n_state = S_STAT;
                    endcase
                end
            end
            // selective mark
            S_ACK_MARK: begin
                if (r_cum != r_sel && r_sel >= r_base &&
                    (r_sel - r_base) < 32'(r_filled)) begin
                    st_we = 1'b1; st_waddr = r_sel[SW-1:0]; st_wdata = ST_ACKED;
                    n_vld[r_sel[SW-1:0]] = 1'b1;
                end
                n_state = S_ACK_RD;
            end
            S_ACK_RD: n_state = S_ACK_DUP;
            // duplicate ack handling, base slot status is on the read port
            S_ACK_DUP: begin
                if (r_fast) begin
                    if (r_high == r_cum) begin
                        dup_n = (r_dup < 2'd3) ? r_dup + 2'd1 : r_dup;
                        n_dup = dup_n;
                        if (dup_n == 2'd2) begin
                            if (!r_pun) begin
                                ss_new = f_shrink(r_cwnd);
                                n_ss   = ss_new;
                                c_new  = (ss_new > 16'(DEPTH_C)) ? DEPTH_C : CW'(ss_new);
                                n_cwnd = c_new;
                                n_mark = f_mark(r_base, c_new);
                                n_pun  = 1'b1;
                            end
                            if (r_filled != '0 && (st_eff == ST_SENT || st_eff == ST_RESENT)) begin
                                st_we = 1'b1; st_waddr = base_slot; st_wdata = ST_TIMEOUT;
                                n_vld[base_slot] = 1'b1;
                                n_rdy = 1'b1;
                            end
                        end
                    end else if (r_high < r_cum) begin
                        n_high = r_cum;
                        n_dup  = '0;
                    end
                end
                n_state = S_ACK_SLID;
            end
            // cumulative slide, clipped to the filled slots
            S_ACK_SLID: begin
                if (r_cum > r_base) begin
                    d = r_cum - r_base;
                    if (d > 32'(r_filled)) begin
                        d = 32'(r_filled);
                        n_err = 1'b1;
                    end
                    n_base   = r_base + d;
                    n_filled = r_filled - CW'(d);
                end
                n_state = S_ACK_GROW;
            end
            // window growth
            S_ACK_GROW: begin
                if (r_base >= r_mark) begin
                    if (16'(r_cwnd) < r_ss) begin
                        g = 17'(r_cwnd) << 1;
                        if (g >= 17'(r_ss)) g = 17'(r_ss);
                    end else begin
                        g = 17'(r_cwnd) + 17'(GROW_STEP);
                    end
                    c_new  = (g > 17'(DEPTH_C)) ? DEPTH_C : CW'(g);
                    n_cwnd = c_new;
                    n_mark = f_mark(r_base, c_new);
                end
                n_state = S_ACK_GROW + 4'd1;
            end
            // refill with unsent slots
            S_ACK_FILL: begin
                avail  = r_total - r_base;
                target = (avail < 32'(r_cwnd)) ? CW'(avail) : r_cwnd;
                if (r_filled < target) begin
                    for (int k = 0; k < WINDOW_DEPTH; k++) begin
                        if (CW'(f_off(SW'(k), base_slot)) >= r_filled &&
                            CW'(f_off(SW'(k), base_slot)) < target) begin
                            n_vld[k] = 1'b0;
                        end
                    end
                    n_filled = target;
                end
                n_idx   = '0;
                n_state = r_rdy ? S_STAT : S_SCAN_RD;
            end
            // present the next slot to the read port
            S_SCAN_RD: begin
                if (r_idx >= lim || (r_cmd == CMD_ACK && r_rdy)) begin
                    case (r_cmd)
                        CMD_TICK: n_state = S_TICK_END;
                        CMD_SEND: n_state = S_SEND_END;
                        default:  n_state = S_STAT;
                    endcase
                end else begin
                    n_state = S_SCAN_EX;
                end
            end
            // act on the slot data
            S_SCAN_EX: begin
                case (r_cmd)
                    CMD_ACK: begin
                        if (st_eff inside {ST_NOT_SENT, ST_TIMEOUT}) n_rdy = 1'b1;
                        n_idx = r_idx + 1'b1; n_state = S_SCAN_RD;
                    end
                    CMD_TICK: begin
                        timed = (st_eff == ST_SENT || st_eff == ST_RESENT) &&
                                (elapsed > r_timeout);
                        if (timed) begin
                            st_we = 1'b1; st_wdata = ST_TIMEOUT;
                            n_vld[scan_seq[SW-1:0]] = 1'b1;
                            n_some = 1'b1;
                            st_post = ST_TIMEOUT;
                        end
                        if (st_post inside {ST_NOT_SENT, ST_TIMEOUT}) begin
                            if (r_idx < WIN_INIT) n_flo = 1'b1;
                            if (r_idx < r_cwnd) n_fall = 1'b1;
                        end
                        n_idx = r_idx + 1'b1; n_state = S_SCAN_RD;
                    end
                    CMD_SEND: begin
                        if (st_eff inside {ST_NOT_SENT, ST_TIMEOUT}) begin
                            if (!r_pend_v || out_free) begin
                                st_we = 1'b1; tm_we = 1'b1;
                                st_wdata = (st_eff == ST_NOT_SENT) ? ST_SENT : ST_RESENT;
                                n_vld[scan_seq[SW-1:0]] = 1'b1;
                                if (r_pend_v) begin
                                    emit = 1'b1; e_kind = KIND_PACKET; e_seq = r_pend_seq;
                                end
                                n_pend_v = 1'b1; n_pend_seq = scan_seq;
                                n_idx = r_idx + 1'b1; n_state = S_SCAN_RD;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1; n_state = S_SCAN_RD;
                        end
                    end
                    default: n_state = S_STAT;
                endcase
            end
            // timeout penalty and ready update
            S_TICK_END: begin
                if (!r_pun && r_some) begin
                    n_ss   = f_shrink(r_cwnd);
                    n_cwnd = WIN_INIT;
                    n_mark = f_mark(r_base, WIN_INIT);
                    n_pun  = 1'b1;
                    if (!r_rdy && r_flo) n_rdy = 1'b1;
                end else if (!r_rdy && r_fall) begin
                    n_rdy = 1'b1;
                end
                n_state = S_STAT;
            end
            // last send result
            S_SEND_END: begin
                if (out_free) begin
                    emit = 1'b1; e_last = 1'b1;
                    e_kind = r_pend_v ? KIND_PACKET : KIND_NOTHING;
                    e_seq  = r_pend_v ? r_pend_seq : '0;
                    n_rdy = 1'b0; n_pun = 1'b0; n_pend_v = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    emit = 1'b1; e_last = 1'b1; e_kind = KIND_STATUS; e_err = r_err;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // configuration writes; the user must write only while idle, the block itself does not enforce it
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOTAL_PACKETS: begin
                    n_total  = i_cfg_data;
                    n_base   = '0;
                    n_filled = (i_cfg_data < 32'(WIN_INIT)) ? CW'(i_cfg_data) : WIN_INIT;
                    n_cwnd   = WIN_INIT;
                    n_ss     = SSTHRESH_INIT;
                    n_mark   = 32'(WIN_INIT);
                    n_high   = '0;
                    n_dup    = '0;
                    n_pun    = 1'b0;
                    n_rdy    = 1'b1;
                    n_vld    = '0;
                end
                CFG_FAST_RETX:  n_fast = i_cfg_data[0];
                CFG_TIMEOUT_US: n_timeout = i_cfg_data;
                default: ;
            endcase
        end
    end

    // control and window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
            r_total     <= 32'd1;
            r_fast      <= 1'b0;
            r_timeout   <= TIMEOUT_INIT;
            r_base      <= '0;
            r_filled    <= CW'(1);
            r_cwnd      <= WIN_INIT;
            r_ss        <= SSTHRESH_INIT;
            r_mark      <= 32'(WIN_INIT);
            r_high      <= '0;
            r_dup       <= '0;
            r_pun       <= 1'b0;
            r_rdy       <= 1'b1;
            r_vld       <= '0;
        end else begin
            r_state   <= n_state;
            r_pend_v  <= n_pend_v;
            r_total   <= n_total;
            r_fast    <= n_fast;
            r_timeout <= n_timeout;
            r_base    <= n_base;
            r_filled  <= n_filled;
            r_cwnd    <= n_cwnd;
            r_ss      <= n_ss;
            r_mark    <= n_mark;
            r_high    <= n_high;
            r_dup     <= n_dup;
            r_pun     <= n_pun;
            r_rdy     <= n_rdy;
            r_vld     <= n_vld;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and scan payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cum      <= n_cum;
        r_sel      <= n_sel;
        r_now      <= n_now;
        r_idx      <= n_idx;
        r_err      <= n_err;
        r_some     <= n_some;
        r_flo      <= n_flo;
        r_fall     <= n_fall;
        r_pend_seq <= n_pend_seq;
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= e_kind;
            r_seq    <= e_seq;
            r_fin    <= (e_kind == KIND_PACKET) && (r_total != '0) &&
                        (e_seq == r_total - 32'd1);
            r_last   <= e_last;
            r_cwnd_o <= 7'(r_cwnd);
            r_ss_o   <= r_ss;
            r_done   <= (r_base >= r_total);
            r_dready <= (e_kind == KIND_STATUS) ? r_rdy : 1'b0;
            r_aerr   <= e_err;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_seq_num         = r_seq;
    assign o_is_final_packet = r_fin;
    assign o_last            = r_last;
    assign o_cwnd_out        = r_cwnd_o;
    assign o_ssthresh_out    = r_ss_o;
    assign o_done_res        = r_done;
    assign o_data_ready      = r_dready;
    assign o_ack_error       = r_aerr;

endmodule

>>> rtl/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> bench/selective_repeat_sender_window_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_tb
// Drives acks, timeout ticks and send requests into the sender window and
// checks every result against a cycle-free model of the window kept in the
// bench, over several transfer sizes, timeouts and fast-retransmit settings.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_tb;
    import srsw_pkg::*;

    localparam int DEPTH = DEF_WINDOW_DEPTH;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [31:0] i_cum_seq;
    logic [31:0] i_sel_seq;
    logic [31:0] i_now_us;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [31:0] o_seq_num;
    logic        o_is_final_packet;
    logic        o_last;
    logic [6:0]  o_cwnd_out;
    logic [15:0] o_ssthresh_out;
    logic        o_done_res;
    logic        o_data_ready;
    logic        o_ack_error;

    selective_repeat_sender_window #(.WINDOW_DEPTH(DEPTH)) dut (.*);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq;
        logic        fin;
        logic        last;
        logic [6:0]  cwnd;
        logic [15:0] ssth;
        logic        done;
        logic        rdy;
        logic        err;
    } t_win_result;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] cum;
        logic [31:0] sel;
        logic [31:0] now;
        bit          typed;
        logic [1:0]  kind;
        logic        err;
    } t_stim_row;

    t_win_result result_q[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          idle_on = 1'b1;
    bit          row_typed = 1'b0;
    logic [1:0]  row_kind;
    logic        row_err;
    bit          chk_typed = 1'b0;
    logic [1:0]  chk_kind;
    logic        chk_err;
    int          stall_left = 0;
    logic [31:0] clock_us = 0;

    // window model state and configuration
    logic [2:0]  slot_st[DEPTH];
    logic [31:0] slot_t[DEPTH];
    logic [31:0] w_base, w_filled, w_cwnd, w_ssth, w_mark, w_hack, w_dup;
    bit          w_pun, w_rdy;
    logic [31:0] c_total = 1;
    bit          c_fast = 1'b0;
    logic [31:0] c_tmo = TIMEOUT_INIT;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // window model
    function automatic logic [31:0] mark_at(logic [31:0] w);
        logic [32:0] m;
        m = {1'b0, w_base} + w;
        return m[32] ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    function automatic logic [31:0] cap_win(logic [31:0] w);
        return (w > DEPTH) ? DEPTH : w;
    endfunction

    function automatic void refill_window();
        while (w_filled < w_cwnd && ({32'd0, w_base} + w_filled) < {32'd0, c_total}) begin
            slot_st[(w_base + w_filled) % DEPTH] = ST_NOT_SENT;
            w_filled++;
        end
    endfunction

    function automatic void rescan_ready();
        logic [2:0] s;
        if (w_rdy) return;
        for (int i = 0; i < w_filled && i < w_cwnd; i++) begin
            s = slot_st[(w_base + i) % DEPTH];
            if (s == ST_NOT_SENT || s == ST_TIMEOUT) begin
                w_rdy = 1'b1;
                return;
            end
        end
    endfunction

    function automatic logic [31:0] shrunk_thresh();
        logic [31:0] t;
        t = (w_cwnd * 62) / 100;
        return (t < THRESH_MIN) ? THRESH_MIN : t;
    endfunction

    function automatic void restart_window();
        for (int i = 0; i < DEPTH; i++) slot_st[i] = ST_NOT_SENT;
        w_base = 0;
        w_filled = 0;
        w_cwnd = cap_win(WIN_MIN);
        w_ssth = SSTHRESH_INIT;
        w_mark = mark_at(w_cwnd);
        w_hack = 0;
        w_dup = 0;
        w_pun = 1'b0;
        w_rdy = 1'b1;
        refill_window();
    endfunction

    function automatic logic apply_ack(logic [31:0] cum, logic [31:0] sel);
        logic        err;
        logic [31:0] d;
        logic [5:0]  s;
        err = 1'b0;
        if (cum != sel && sel >= w_base && sel - w_base < w_filled)
            slot_st[sel % DEPTH] = ST_ACKED;
        if (c_fast) begin
            if (w_hack == cum) begin
                if (w_dup < 3) w_dup++;
                if (w_dup == 2) begin
                    if (!w_pun) begin
                        w_ssth = shrunk_thresh();
                        w_cwnd = cap_win(w_ssth);
                        w_mark = mark_at(w_cwnd);
                        w_pun = 1'b1;
                    end
                    if (w_filled > 0) begin
                        s = w_base % DEPTH;
                        if (slot_st[s] == ST_SENT || slot_st[s] == ST_RESENT) begin
                            slot_st[s] = ST_TIMEOUT;
                            w_rdy = 1'b1;
                        end
                    end
                end
            end else if (w_hack < cum) begin
                w_hack = cum;
                w_dup = 0;
            end
        end
        // cumulative slide, clipped to the filled slots
        if (cum > w_base) begin
            d = cum - w_base;
            if (d > w_filled) begin
                d = w_filled;
                err = 1'b1;
            end
            w_base += d;
            w_filled -= d;
        end
        // slow start doubles, then additive growth
        if (w_base >= w_mark) begin
            if (w_cwnd < w_ssth) begin
                w_cwnd *= 2;
                if (w_cwnd >= w_ssth) w_cwnd = w_ssth;
            end else begin
                w_cwnd += GROW_STEP;
            end
            w_cwnd = cap_win(w_cwnd);
            w_mark = mark_at(w_cwnd);
        end
        refill_window();
        rescan_ready();
        return err;
    endfunction

    function automatic void apply_tick(logic [31:0] now);
        bit         some;
        logic [5:0] s;
        some = 1'b0;
        for (int i = 0; i < w_filled; i++) begin
            s = (w_base + i) % DEPTH;
            if ((slot_st[s] == ST_SENT || slot_st[s] == ST_RESENT) &&
                    (now - slot_t[s]) > c_tmo) begin
                slot_st[s] = ST_TIMEOUT;
                some = 1'b1;
            end
        end
        if (!w_pun && some) begin
            w_ssth = shrunk_thresh();
            w_cwnd = cap_win(WIN_MIN);
            w_mark = mark_at(w_cwnd);
            w_pun = 1'b1;
        end
        rescan_ready();
    endfunction

    function automatic t_win_result make_result(logic [1:0] kind, logic [31:0] seq,
                                                logic fin, logic err);
        t_win_result r;
        r.kind = kind;
        r.seq  = seq;
        r.fin  = fin;
        r.last = 1'b0;
        r.cwnd = w_cwnd[6:0];
        r.ssth = w_ssth[15:0];
        r.done = (w_base >= c_total);
        r.rdy  = w_rdy;
        r.err  = err;
        return r;
    endfunction

    // expected results of one accepted item
    function automatic void predict_window(logic [1:0] cmd, logic [31:0] cum,
                                           logic [31:0] sel, logic [31:0] now);
        int          n;
        logic [31:0] seq;
        logic [5:0]  s;
        logic        err;
        t_win_result r;
        n = 0;
        if (cmd == CMD_SEND) begin
            for (int i = 0; i < w_cwnd && i < w_filled; i++) begin
                seq = w_base + i;
                s = seq % DEPTH;
                if (slot_st[s] == ST_NOT_SENT || slot_st[s] == ST_TIMEOUT) begin
                    slot_st[s] = (slot_st[s] == ST_NOT_SENT) ? ST_SENT : ST_RESENT;
                    slot_t[s] = now;
                    r = make_result(KIND_PACKET, seq,
                                    c_total != 0 && seq == c_total - 1, 1'b0);
                    r.rdy = 1'b0;
                    result_q.insert(result_q.size(), r);
                    n++;
                end
            end
            w_rdy = 1'b0;
            w_pun = 1'b0;
            if (n == 0) begin
                result_q.insert(result_q.size(), make_result(KIND_NOTHING, 0, 1'b0, 1'b0));
            end
        end else begin
            err = 1'b0;
            if (cmd == CMD_ACK) err = apply_ack(cum, sel);
            else if (cmd == CMD_TICK) apply_tick(now);
            result_q.insert(result_q.size(), make_result(KIND_STATUS, 0, 1'b0, err));
        end
        result_q[$].last = 1'b1;
    endfunction

    task automatic check_field(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    // input acceptance and result checking
    always @(posedge i_clk) begin
        t_win_result e;
        int          first;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            first = result_q.size();
            predict_window(i_cmd, i_cum_seq, i_sel_seq, i_now_us);
            if (chk_typed) begin
                result_q[first].kind = chk_kind;
                result_q[first].err = chk_err;
            end
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $error("result with nothing expected: kind %0d seq %0d", o_kind, o_seq_num);
                errors++;
            end else begin
                e = result_q[0];
                result_q.delete(0);
                check_field("kind", e.kind, o_kind);
                check_field("seq_num", e.seq, o_seq_num);
                check_field("is_final_packet", e.fin, o_is_final_packet);
                check_field("last", e.last, o_last);
                check_field("cwnd_out", e.cwnd, o_cwnd_out);
                check_field("ssthresh_out", e.ssth, o_ssthresh_out);
                check_field("done_res", e.done, o_done_res);
                check_field("data_ready", e.rdy, o_data_ready);
                check_field("ack_error", e.err, o_ack_error);
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drive_item(logic [1:0] cmd, logic [31:0] cum, logic [31:0] sel,
                              logic [31:0] now);
        // sender gap burst
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_cmd <= cmd;
        i_cum_seq <= cum;
        i_sel_seq <= sel;
        i_now_us <= now;
        chk_typed <= row_typed;
        chk_kind <= row_kind;
        chk_err <= row_err;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        row_typed = 1'b0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TOTAL_PACKETS: begin
                c_total = data;
                restart_window();
            end
            CFG_FAST_RETX: c_fast = data[0];
            CFG_TIMEOUT_US: c_tmo = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // mostly well-formed traffic around the live window, some noise
    task automatic random_item();
        int unsigned pick;
        logic [31:0] cum, sel;
        clock_us += $urandom_range(0, 120);
        pick = $urandom_range(0, 99);
        cum = w_base + $urandom_range(0, w_filled);
        sel = w_base + $urandom_range(0, w_filled + 2);
        if ($urandom_range(0, 9) == 0) cum = $urandom;
        if ($urandom_range(0, 9) == 0) sel = $urandom;
        if (pick < 35)
            drive_item(CMD_SEND, $urandom, $urandom, clock_us);
        else if (pick < 75)
            drive_item(CMD_ACK, cum, sel, clock_us);
        else if (pick < 95)
            drive_item(CMD_TICK, $urandom, $urandom,
                       ($urandom_range(0, 15) == 0) ? $urandom : clock_us);
        else
            drive_item(2'd3, $urandom, $urandom, $urandom);
    endtask

    t_stim_row rows[$];

    initial begin
        logic [31:0] tot;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TOTAL_PACKETS;
        i_cfg_data = 0;
        i_in_valid = 1'b0;
        i_cmd = CMD_ACK;
        i_cum_seq = 0;
        i_sel_seq = 0;
        i_now_us = 0;
        i_out_ready = 1'b0;
        restart_window();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one-packet transfer after reset
        rows = '{
            '{CMD_SEND, 0, 0, 0, 1, KIND_PACKET, 0},
            '{CMD_ACK, 1, 1, 0, 1, KIND_STATUS, 0},
            '{CMD_SEND, 0, 0, 0, 1, KIND_NOTHING, 0},
            '{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, KIND_STATUS, 0}
        };
        foreach (rows[i]) begin
            row_typed = rows[i].typed;
            row_kind = rows[i].kind;
            row_err = rows[i].err;
            drive_item(rows[i].cmd, rows[i].cum, rows[i].sel, rows[i].now);
        end
        wait_drained();

        // directed: 40 packets, fast retransmit, short timeout
        write_reg(CFG_TOTAL_PACKETS, 40);
        write_reg(CFG_FAST_RETX, 1);
        write_reg(CFG_TIMEOUT_US, 100);
        rows = '{
            '{CMD_SEND, 0, 0, 1000, 0, KIND_PACKET, 0},
            '{CMD_ACK, 0, 3, 1010, 0, KIND_STATUS, 0},
            '{CMD_ACK, 0, 500, 1020, 0, KIND_STATUS, 0},
            '{CMD_ACK, 0, 0, 1030, 0, KIND_STATUS, 0},
            '{CMD_SEND, 0, 0, 1040, 0, KIND_PACKET, 0},
            '{CMD_TICK, 0, 0, 1050, 0, KIND_STATUS, 0},
            '{CMD_TICK, 0, 0, 1300, 0, KIND_STATUS, 0},
            '{CMD_SEND, 0, 0, 1400, 0, KIND_PACKET, 0},
            '{CMD_ACK, 4, 6, 1410, 0, KIND_STATUS, 0},
            '{CMD_ACK, 63, 7, 1420, 1, KIND_STATUS, 1},
            '{CMD_SEND, 0, 0, 32'hFFFF_FFF0, 0, KIND_PACKET, 0},
            '{CMD_TICK, 0, 0, 32'hFFFF_FFFF, 0, KIND_STATUS, 0},
            '{CMD_TICK, 0, 0, 200, 0, KIND_STATUS, 0},
            '{CMD_SEND, 0, 0, 300, 0, KIND_PACKET, 0},
            '{CMD_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 310, 1, KIND_STATUS, 1},
            '{CMD_SEND, 0, 0, 320, 0, KIND_PACKET, 0}
        };
        foreach (rows[i]) begin
            row_typed = rows[i].typed;
            row_kind = rows[i].kind;
            row_err = rows[i].err;
            drive_item(rows[i].cmd, rows[i].cum, rows[i].sel, rows[i].now);
        end
        wait_drained();

        // zero packets: done at once
        write_reg(CFG_TOTAL_PACKETS, 0);
        drive_item(CMD_SEND, 0, 0, 0);
        drive_item(CMD_ACK, 5, 2, 0);
        wait_drained();

        // random phases over several settings, extremes among them
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: tot = 32'hFFFF_FFFF;
                1: tot = 1;
                default: tot = $urandom_range(2, 400);
            endcase
            write_reg(CFG_TOTAL_PACKETS, tot);
            write_reg(CFG_FAST_RETX, $urandom_range(0, 1));
            case (ph % 3)
                0: write_reg(CFG_TIMEOUT_US, 0);
                1: write_reg(CFG_TIMEOUT_US, $urandom_range(20, 400));
                default: write_reg(CFG_TIMEOUT_US, (ph == 5) ? 32'hFFFF_FFFF : 32'd150);
            endcase
            if (ph == 6) idle_on = 1'b0;
            repeat (21) random_item();
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d expected results never came", result_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
